### rtl/rbd_pkg.sv
package rbd_pkg;

  // ring size and derived widths
  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic exec;
    logic load_out;
  } rbd_cmd_t;

  // index step forward with wrap
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // index step backward with wrap
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

endpackage

### rtl/rbd_if.sv
// request channel
interface rbd_req_if import rbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output mode, output data_in, input ready);
  modport sink   (input valid, input mode, input data_in, output ready);
endinterface

// response channel
interface rbd_rsp_if import rbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output data_out, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input data_out, input status, input is_empty,
                  input is_full, output ready);
endinterface

### rtl/ring_buffer_deque.sv
// Double-ended queue of 32-bit signed words kept in a ring of DEPTH entries
// (capacity DEPTH-1). Each request pushes or pops at the front or the back and
// returns one response with the popped word (0 for pushes and rejects), a
// status (ok, full, empty) and the empty and full flags after the request. A
// push while full or a pop while empty changes nothing. The accepting edge of a
// request moves the indices, writes the ring for an accepted push and registers
// a ring read; a later edge, once the response register is free or being
// drained, loads it from that registered read. Only then is the next request
// taken, so a new request is not accepted before the last response is loaded.
// The response register keeps a finished response while a new request is taken.
// Ring contents are not cleared at reset; both indices reset to DEPTH-1.
module ring_buffer_deque import rbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  rbd_req_if.sink          req_i,
  rbd_rsp_if.source        rsp_o
);

  rbd_cmd_t cmd;

  // sequencing of request and response
  rbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // indices, ring storage and response register
  rbd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mode_i     (req_i.mode),
    .data_i     (req_i.data_in),
    .data_out_o (rsp_o.data_out),
    .status_o   (rsp_o.status),
    .is_empty_o (rsp_o.is_empty),
    .is_full_o  (rsp_o.is_full)
  );

endmodule

### rtl/rbd_ctrl.sv
module rbd_ctrl import rbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output rbd_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  // state and response valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d      = state_q;
    req_ready_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_RESP;
        end
      end
      ST_RESP: begin
        // output register free or being drained this cycle
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // response valid follows output register loads
  always_comb begin
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

### rtl/rbd_datapath.sv
module rbd_datapath import rbd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rbd_cmd_t                 cmd_i,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [DATA_W-1:0] data_i,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     is_empty_o,
  output logic                     is_full_o
);

  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] back_q, back_d;
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en;
  logic             pop_ok_d, pop_ok_q;
  status_e          status_d, status_q;
  logic             empty, full;

  logic signed [DATA_W-1:0] out_data_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic                     out_empty_q, out_full_q;

  // occupancy from the indices
  assign empty = (front_q == back_q);
  assign full  = (idx_dec(back_q) == front_q);

  // index update and ring access per request
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    wr_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    pop_ok_d = 1'b0;
    status_d = STAT_OK;
    case (mode_e'(mode_i))
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          front_d = idx_inc(front_q);
          wr_en   = 1'b1;
          wr_addr = idx_inc(front_q);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_q;
          back_d  = idx_dec(back_q);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_addr  = front_q;
          front_d  = idx_dec(front_q);
          pop_ok_d = 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          back_d   = idx_inc(back_q);
          rd_addr  = idx_inc(back_q);
          pop_ok_d = 1'b1;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  // front and back indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= LAST_IDX;
      back_q  <= LAST_IDX;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
    end
  end

  // ring storage, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= data_i;
    end
    if (cmd_i.exec) begin
      rd_q <= mem[rd_addr];
    end
  end

  // per-request result bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // response register, flags taken from the updated indices
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= pop_ok_q ? rd_q : '0;
      out_status_q <= status_q;
      out_empty_q  <= empty;
      out_full_q   <= full;
    end
  end

  assign data_out_o = out_data_q;
  assign status_o   = out_status_q;
  assign is_empty_o = out_empty_q;
  assign is_full_o  = out_full_q;

`ifndef SYNTHESIS
  // a rejected request leaves both indices alone
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (status_d != STAT_OK) |=> $stable(front_q) && $stable(back_q))
    else $error("rejected request moved an index");

  // an accepted push leaves the deque non-empty
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && wr_en |=> front_q != back_q)
    else $error("deque empty after a push");

  // an accepted pop leaves room for another item
  a_pop_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && pop_ok_d |=> idx_dec(back_q) != front_q)
    else $error("deque full after a pop");

  // pops never write the ring
  a_pop_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && pop_ok_d |-> !wr_en)
    else $error("pop request writes the ring");
`endif

endmodule
